// File: sv/sblru_pkg.sv
// ----------------------------------------------------------------------------
// sblru_pkg
// Shared types, codes and saturating arithmetic for the size-budget LRU cache.
// ----------------------------------------------------------------------------
package sblru_pkg;

   localparam int TotalW = 48;
   localparam int KeyW   = 32;
   localparam int SizeW  = 32;
   localparam int TimeW  = 32;
   localparam int CntW   = 5;

   typedef enum logic [1:0] {
      REQ_FETCH  = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_TRIM   = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_BUMP,
      OP_WRITE,
      OP_DROP,
      OP_FILL
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_EVICT,
      ST_INSERT,
      ST_TRIM,
      ST_RESP
   } state_type;

   // Command broadcast to every cell of the row
   typedef struct packed {
      cell_op_type         op;
      logic [KeyW-1:0]     key;
      logic [SizeW-1:0]    size;
      logic [TimeW-1:0]    stamp;
   } cell_cmd_type;

   function automatic logic [TotalW-1:0] sat_add(input logic [TotalW-1:0] a,
                                                 input logic [SizeW-1:0]  b);
      logic [TotalW:0] sum;
      sum = {1'b0, a} + (TotalW+1)'(b);
      return sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0];
   endfunction

   function automatic logic [TotalW-1:0] sat_sub(input logic [TotalW-1:0] a,
                                                 input logic [SizeW-1:0]  b);
      return (a > TotalW'(b)) ? (a - TotalW'(b)) : '0;
   endfunction

endpackage

// File: sv/sblru_if.sv
// ----------------------------------------------------------------------------
// sblru interfaces
// Request, response and register-write channels of the LRU cache.
// ----------------------------------------------------------------------------
interface sblru_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] key;
   logic [31:0] entry_size;
   logic [31:0] entry_time;
   modport source (output valid, req_type, key, entry_size, entry_time, input ready);
   modport sink   (input valid, req_type, key, entry_size, entry_time, output ready);
endinterface

interface sblru_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] stored_time;
   logic        had_effect;
   logic [47:0] total_used;
   logic [4:0]  evicted_count;
   logic [4:0]  entry_count;
   modport source (output valid, hit, stored_time, had_effect, total_used,
                   evicted_count, entry_count, input ready);
   modport sink   (input valid, hit, stored_time, had_effect, total_used,
                   evicted_count, entry_count, output ready);
endinterface

interface sblru_csr_if;
   logic        valid;
   logic        ready;
   logic [47:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: sv/sblru_cell.sv
// ----------------------------------------------------------------------------
// sblru_cell
// One directory slot: key, size, timestamp and recency rank. Ranks of all
// cells always form a permutation; valid cells hold the lowest ranks.
// ----------------------------------------------------------------------------
module sblru_cell
   import sblru_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int IDX     = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cell_cmd_type                 cmd,
   input  logic [$clog2(ENTRIES)-1:0]   cmd_rank,
   input  logic [$clog2(ENTRIES)-1:0]   cmd_top,
   output logic                         valid,
   output logic [$clog2(ENTRIES)-1:0]   rank,
   output logic [KeyW-1:0]              key,
   output logic [SizeW-1:0]             size,
   output logic [TimeW-1:0]             stamp
);
   localparam int RW = $clog2(ENTRIES);

   logic          valid_ff;
   logic [RW-1:0] rank_ff;
   logic [KeyW-1:0]  key_ff;
   logic [SizeW-1:0] size_ff;
   logic [TimeW-1:0] stamp_ff;
   logic          sel;
   logic          above;

   assign sel   = (rank_ff == cmd_rank);
   assign above = (rank_ff > cmd_rank);

   // Update recency and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= RW'(IDX);
      end else begin
         case (cmd.op) inside
            OP_BUMP, OP_WRITE: begin
               if (valid_ff && sel) rank_ff <= cmd_top;
               else if (valid_ff && above) rank_ff <= rank_ff - 1'b1;
            end
            OP_DROP: begin
               if (valid_ff && sel) begin
                  valid_ff <= 1'b0;
                  rank_ff  <= RW'(ENTRIES - 1);
               end else if (above) begin
                  rank_ff <= rank_ff - 1'b1;
               end
            end
            OP_FILL: begin
               if (!valid_ff && sel) valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Hold the payload words
   always_ff @(posedge clock) begin
      if (cmd.op == OP_FILL && !valid_ff && sel) begin
         key_ff   <= cmd.key;
         size_ff  <= cmd.size;
         stamp_ff <= cmd.stamp;
      end else if (cmd.op == OP_WRITE && valid_ff && sel) begin
         size_ff  <= cmd.size;
         stamp_ff <= cmd.stamp;
      end
   end

   assign valid = valid_ff;
   assign rank  = rank_ff;
   assign key   = key_ff;
   assign size  = size_ff;
   assign stamp = stamp_ff;
endmodule

// File: sv/size_budget_lru_cache.sv
// ----------------------------------------------------------------------------
// size_budget_lru_cache
// LRU cache directory with a byte budget, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. A request is taken when req_if.ready is
// high and first passes the lookup state, in which a fetch, a replace or a
// remove of a present key also updates the cell row. A new insert then passes
// the fill state, preceded by the evict state when the table is full and the
// least recent entry goes first. Every request other than a fetch or a remove
// of an absent key then runs the budget check, which evicts least recent
// entries while a nonzero budget is exceeded and more than one entry is left.
// The result word is then held until taken, and the next request is accepted
// after that. Every eviction is one broadcast to the cell row. Register
// writes are accepted in any cycle.
module size_budget_lru_cache
   import sblru_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic  clock,
   input  logic  reset,
   sblru_req_if.sink   req_if,
   sblru_rsp_if.source rsp_if,
   sblru_csr_if.sink   csr_if
);
   localparam int RW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   state_type state_ff, state_in;

   logic [TotalW-1:0] max_ff;
   logic [TotalW-1:0] total_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     evict_ff;
   req_code_type      type_ff;
   logic [KeyW-1:0]   key_ff;
   logic [SizeW-1:0]  size_ff;
   logic [TimeW-1:0]  time_ff;
   logic              hit_ff;
   logic              eff_ff;
   logic [TimeW-1:0]  stime_ff;

   cell_cmd_type   cmd;
   logic [RW-1:0]  cmd_rank;
   logic [RW-1:0]  cmd_top;

   logic [ENTRIES-1:0] c_valid;
   logic [RW-1:0]      c_rank  [ENTRIES];
   logic [KeyW-1:0]    c_key   [ENTRIES];
   logic [SizeW-1:0]   c_size  [ENTRIES];
   logic [TimeW-1:0]   c_stamp [ENTRIES];

   logic              m_hit;
   logic [RW-1:0]     m_rank;
   logic [SizeW-1:0]  m_size;
   logic [TimeW-1:0]  m_time;
   logic [SizeW-1:0]  z_size;
   logic              trim_go;

   // Cell row
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      sblru_cell #(.ENTRIES(ENTRIES), .IDX(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .cmd_rank (cmd_rank),
         .cmd_top  (cmd_top),
         .valid    (c_valid[g]),
         .rank     (c_rank[g]),
         .key      (c_key[g]),
         .size     (c_size[g]),
         .stamp    (c_stamp[g])
      );
   end

   // Collect the matching slot and the least recent slot
   always_comb begin
      m_hit  = 1'b0;
      m_rank = '0;
      m_size = '0;
      m_time = '0;
      z_size = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (c_valid[i] && c_key[i] == key_ff) begin
            m_hit  = 1'b1;
            m_rank = m_rank | c_rank[i];
            m_size = m_size | c_size[i];
            m_time = m_time | c_stamp[i];
         end
         if (c_valid[i] && c_rank[i] == '0) z_size = z_size | c_size[i];
      end
   end

   assign trim_go = (max_ff != '0) && (count_ff > CW'(1)) && (total_ff > max_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_if.valid) state_in = ST_LOOK;
         ST_LOOK: begin
            unique case (type_ff)
               REQ_FETCH:  state_in = ST_RESP;
               REQ_INSERT: begin
                  if (m_hit) state_in = ST_TRIM;
                  else if (count_ff == CW'(ENTRIES)) state_in = ST_EVICT;
                  else state_in = ST_INSERT;
               end
               REQ_REMOVE: state_in = m_hit ? ST_TRIM : ST_RESP;
               REQ_TRIM:   state_in = ST_TRIM;
               default:    state_in = ST_RESP;
            endcase
         end
         ST_EVICT:  state_in = ST_INSERT;
         ST_INSERT: state_in = ST_TRIM;
         ST_TRIM:   if (!trim_go) state_in = ST_RESP;
         ST_RESP:   if (rsp_if.ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Cell commands
   always_comb begin
      cmd.op    = OP_NONE;
      cmd.key   = key_ff;
      cmd.size  = size_ff;
      cmd.stamp = time_ff;
      cmd_rank  = '0;
      cmd_top   = RW'(count_ff - 1'b1);
      unique case (state_ff)
         ST_LOOK: begin
            cmd_rank = m_rank;
            if (m_hit) begin
               case (type_ff)
                  REQ_FETCH:  cmd.op = OP_BUMP;
                  REQ_INSERT: cmd.op = OP_WRITE;
                  REQ_REMOVE: cmd.op = OP_DROP;
                  default:    cmd.op = OP_NONE;
               endcase
            end
         end
         ST_EVICT:  cmd.op = OP_DROP;
         ST_INSERT: begin
            cmd.op   = OP_FILL;
            cmd_rank = RW'(count_ff);
         end
         ST_TRIM:   if (trim_go) cmd.op = OP_DROP;
         default:   cmd.op = OP_NONE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_ff   <= '0;
         total_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_if.valid) max_ff <= csr_if.data;
         case (state_ff)
            ST_LOOK: begin
               if (m_hit && type_ff == REQ_INSERT) begin
                  total_ff <= sat_add(sat_sub(total_ff, m_size), size_ff);
               end else if (m_hit && type_ff == REQ_REMOVE) begin
                  total_ff <= sat_sub(total_ff, m_size);
                  count_ff <= count_ff - 1'b1;
               end
            end
            ST_EVICT: begin
               total_ff <= sat_sub(total_ff, z_size);
               count_ff <= count_ff - 1'b1;
            end
            ST_INSERT: begin
               total_ff <= sat_add(total_ff, size_ff);
               count_ff <= count_ff + 1'b1;
            end
            ST_TRIM: begin
               if (trim_go) begin
                  total_ff <= sat_sub(total_ff, z_size);
                  count_ff <= count_ff - 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Request word and result fields
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               type_ff  <= req_code_type'(req_if.req_type);
               key_ff   <= req_if.key;
               size_ff  <= req_if.entry_size;
               time_ff  <= req_if.entry_time;
               hit_ff   <= 1'b0;
               eff_ff   <= 1'b0;
               stime_ff <= '0;
               evict_ff <= '0;
            end
         end
         ST_LOOK: begin
            if (type_ff != REQ_TRIM) hit_ff <= m_hit;
            if (type_ff == REQ_FETCH && m_hit) stime_ff <= m_time;
            if (type_ff == REQ_INSERT || (type_ff == REQ_REMOVE && m_hit)) eff_ff <= 1'b1;
         end
         ST_EVICT: evict_ff <= evict_ff + 1'b1;
         ST_TRIM:  if (trim_go) evict_ff <= evict_ff + 1'b1;
         default: ;
      endcase
   end

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign csr_if.ready         = 1'b1;
   assign rsp_if.valid         = (state_ff == ST_RESP);
   assign rsp_if.hit           = hit_ff;
   assign rsp_if.stored_time   = stime_ff;
   assign rsp_if.had_effect    = eff_ff;
   assign rsp_if.total_used    = total_ff;
   assign rsp_if.evicted_count = CntW'(evict_ff);
   assign rsp_if.entry_count   = CntW'(count_ff);
endmodule
